@@ rtl/core/dtfp_pkg.sv @@
`timescale 1ns / 1ps

package dtfp_pkg;

  // Sequencer states.
  typedef enum logic [0:0] {
    StIdle,
    StPad
  } state_e;

  // Character codes and limits.
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharPoint = 8'd46;

  localparam int unsigned FracWidth = 5;
  localparam int unsigned FixedWidth = 63;
  localparam logic [FracWidth-1:0] FracLimit = 5'd18;
  localparam logic [FracWidth-1:0] FracReset = 5'd2;

  // Signed character value (code minus 48) needs nine bits.
  localparam int unsigned DigitWidth = 9;

endpackage

@@ rtl/core/decimal_text_to_fixed_point.sv @@
`timescale 1ns / 1ps

// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------------------
// input     | in_valid_i / in_ready_o       | char_code_i, last_char_i
// output    | out_valid_o / out_ready_i     | fixed_value_o, overflow_flag_o, bad_char_flag_o
// config    | frac_digits_we_i (no wait)    | frac_digits_i
//
// Every character but the first point goes through the shared multiply-by-ten adder,
// except fraction digits past the setting. A last character then pads one zero per
// missing fraction digit (up to 18) through the same adder, then loads the result.
// The load waits while the previous result is still unaccepted.
// Reset clears the accumulator, working flags, output valid and sequencer, and sets frac_digits to 2.
// Characters keep being accepted while a finished result waits on the output.

module decimal_text_to_fixed_point #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               frac_digits_we_i,
  input  logic [dtfp_pkg::FracWidth-1:0]     frac_digits_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         char_code_i,
  input  logic                               last_char_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dtfp_pkg::FixedWidth-1:0]    fixed_value_o,
  output logic                               overflow_flag_o,
  output logic                               bad_char_flag_o
);

  // Width of acc * 10 + digit as a signed value.
  localparam int unsigned SumWidth = VALUE_WIDTH + 5;

  dtfp_pkg::state_e state_q, state_d;

  logic [dtfp_pkg::FracWidth-1:0] frac_cfg_q;
  logic [dtfp_pkg::FracWidth-1:0] frac_lim;

  logic [VALUE_WIDTH-1:0]         acc_q, acc_d;
  logic                           point_q, point_d;
  logic [dtfp_pkg::FracWidth-1:0] fcount_q, fcount_d;
  logic                           ovf_q, ovf_d;
  logic                           bad_q, bad_d;

  logic                           out_valid_q, out_valid_d;
  logic [dtfp_pkg::FixedWidth-1:0] fixed_q, fixed_d;
  logic                           out_ovf_q, out_ovf_d;
  logic                           out_bad_q, out_bad_d;

  // Shared unit operands and result.
  logic [dtfp_pkg::DigitWidth-1:0] unit_digit;
  logic signed [SumWidth-1:0]      unit_sum;
  logic                            unit_ovf;

  logic is_digit;
  logic is_point;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_cfg_q <= dtfp_pkg::FracReset;
    end else if (frac_digits_we_i) begin
      frac_cfg_q <= frac_digits_i;
    end
  end

  // Values above the limit behave as the limit.
  assign frac_lim = (frac_cfg_q > dtfp_pkg::FracLimit) ? dtfp_pkg::FracLimit : frac_cfg_q;

  // Shared unit: acc * 10 + digit, with an exact range check on the full sum.
  always_comb begin
    unit_sum = SumWidth'({acc_q, 3'b000}) + SumWidth'({acc_q, 1'b0})
             + {{(SumWidth - dtfp_pkg::DigitWidth){unit_digit[dtfp_pkg::DigitWidth-1]}},
                unit_digit};
    unit_ovf = unit_sum[SumWidth-1] || (unit_sum[SumWidth-2:VALUE_WIDTH-1] != '0);
  end

  assign is_digit = (char_code_i >= dtfp_pkg::CharZero) && (char_code_i <= dtfp_pkg::CharNine);
  assign is_point = (char_code_i == dtfp_pkg::CharPoint);

  // Sequencer: next state, datapath control and output loading.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    point_d     = point_q;
    fcount_d    = fcount_q;
    ovf_d       = ovf_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    fixed_d     = fixed_q;
    out_ovf_d   = out_ovf_q;
    out_bad_d   = out_bad_q;
    unit_digit  = '0;
    in_ready_o  = 1'b0;

    // The output register frees up when its transaction completes.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dtfp_pkg::StIdle: begin
        // Always ready here, so a valid character is a transaction.
        in_ready_o = 1'b1;
        unit_digit = {1'b0, char_code_i} - {1'b0, dtfp_pkg::CharZero};
        if (in_valid_i) begin
          if (!point_q && is_point) begin
            point_d = 1'b1;
          end else begin
            if (!is_digit) begin
              bad_d = 1'b1;
            end
            if (!point_q) begin
              acc_d = unit_sum[VALUE_WIDTH-1:0];
              ovf_d = ovf_q || unit_ovf;
            end else if (fcount_q < frac_lim) begin
              acc_d    = unit_sum[VALUE_WIDTH-1:0];
              ovf_d    = ovf_q || unit_ovf;
              fcount_d = fcount_q + 1'b1;
            end
          end
          if (last_char_i) begin
            state_d = dtfp_pkg::StPad;
          end
        end
      end
      dtfp_pkg::StPad: begin
        if (fcount_q < frac_lim) begin
          // Pad one zero fraction digit.
          acc_d    = unit_sum[VALUE_WIDTH-1:0];
          ovf_d    = ovf_q || unit_ovf;
          fcount_d = fcount_q + 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          // Hand the result over and clear for the next number.
          out_valid_d = 1'b1;
          fixed_d     = dtfp_pkg::FixedWidth'(acc_q[VALUE_WIDTH-2:0]);
          out_ovf_d   = ovf_q;
          out_bad_d   = bad_q;
          acc_d       = '0;
          point_d     = 1'b0;
          fcount_d    = '0;
          ovf_d       = 1'b0;
          bad_d       = 1'b0;
          state_d     = dtfp_pkg::StIdle;
        end
      end
      default: begin
        state_d = dtfp_pkg::StIdle;
      end
    endcase
  end

  // Control and accumulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtfp_pkg::StIdle;
      acc_q       <= '0;
      point_q     <= 1'b0;
      fcount_q    <= '0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      point_q     <= point_d;
      fcount_q    <= fcount_d;
      ovf_q       <= ovf_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    fixed_q   <= fixed_d;
    out_ovf_q <= out_ovf_d;
    out_bad_q <= out_bad_d;
  end

  assign out_valid_o     = out_valid_q;
  assign fixed_value_o   = fixed_q;
  assign overflow_flag_o = out_ovf_q;
  assign bad_char_flag_o = out_bad_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] char_t;
  typedef logic [dtfp_pkg::FracWidth-1:0] frac_t;
  typedef logic [dtfp_pkg::FixedWidth-1:0] fixed_t;

  typedef struct packed {
    fixed_t value;
    logic   ovf;
    logic   bad;
  } fixed_result_t;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  localparam logic signed [71:0] MaxSigned = {9'd0, {63{1'b1}}};
  localparam frac_t FracPlan [6] = '{5'd0, 5'd18, 5'd31, 5'd2, 5'd1, 5'd19};
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned CharsPerPhase = 180;
  localparam int unsigned SettleCycles = 25;

  // Tracks the parse state of the number in flight and the fixed-point
  // values that are still owed by the block.
  class number_parse_tracker;
    frac_t         frac_setting;
    logic [63:0]   accum;
    logic          point_seen;
    logic          ovf_seen;
    logic          bad_seen;
    frac_t         frac_taken;
    fixed_result_t owed_values[$];
    int unsigned   mismatches;

    function new();
      frac_setting = dtfp_pkg::FracReset;
      mismatches   = 0;
      clear_number();
    endfunction

    function void clear_number();
      accum      = '0;
      point_seen = 1'b0;
      ovf_seen   = 1'b0;
      bad_seen   = 1'b0;
      frac_taken = '0;
    endfunction

    function void set_frac(frac_t digits);
      frac_setting = digits;
    endfunction

    function int unsigned outstanding();
      return owed_values.size();
    endfunction

    // Multiply by ten and add the character value (code minus 48), which
    // may be negative. The range check is exact on a wide signed sum.
    function void shift_char(char_t code);
      logic signed [71:0] wide;
      wide = $signed({8'd0, accum}) * 72'sd10 + $signed({64'd0, code}) - 72'sd48;
      if (wide < 0 || wide > MaxSigned) ovf_seen = 1'b1;
      accum = wide[63:0];
    endfunction

    // Apply one accepted character; a last character pads and owes a result.
    function void take_char(char_t code, logic last);
      frac_t limit;
      logic  is_digit;
      limit    = (frac_setting > dtfp_pkg::FracLimit) ? dtfp_pkg::FracLimit : frac_setting;
      is_digit = (code >= dtfp_pkg::CharZero) && (code <= dtfp_pkg::CharNine);
      if (!point_seen && code == dtfp_pkg::CharPoint) begin
        point_seen = 1'b1;
      end else begin
        if (!is_digit) bad_seen = 1'b1;
        if (!point_seen) begin
          shift_char(code);
        end else if (frac_taken < limit) begin
          shift_char(code);
          frac_taken = frac_taken + 1'b1;
        end
      end
      if (last) begin
        while (frac_taken < limit) begin
          shift_char(dtfp_pkg::CharZero);
          frac_taken = frac_taken + 1'b1;
        end
        owed_values.push_back(fixed_result_t'{value: accum[dtfp_pkg::FixedWidth-1:0],
                                              ovf: ovf_seen, bad: bad_seen});
        clear_number();
      end
    endfunction

    // Compare one result transaction with the oldest owed value.
    function void match_result(fixed_t value, logic ovf, logic bad);
      fixed_result_t want;
      if (owed_values.size() == 0) begin
        $error("unexpected result: fixed_value %0d", value);
        mismatches++;
        return;
      end
      want = owed_values.pop_front();
      if (value !== want.value) begin
        $error("fixed_value: expected %0d, actual %0d", want.value, value);
        mismatches++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow_flag: expected %0b, actual %0b", want.ovf, ovf);
        mismatches++;
      end
      if (bad !== want.bad) begin
        $error("bad_char_flag: expected %0b, actual %0b", want.bad, bad);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   frac_digits_we_i = 1'b0;
  frac_t  frac_digits_i = '0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  char_t  char_code_i = '0;
  logic   last_char_i = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  fixed_t fixed_value_o;
  logic   overflow_flag_o;
  logic   bad_char_flag_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  number_parse_tracker tracker = new();

  decimal_text_to_fixed_point #(
    .VALUE_WIDTH(64)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frac_digits_we_i(frac_digits_we_i),
    .frac_digits_i   (frac_digits_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fixed_value_o   (fixed_value_o),
    .overflow_flag_o (overflow_flag_o),
    .bad_char_flag_o (bad_char_flag_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels; results are checked before the same-edge character
  // is applied, since a result never depends on a character taken that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.match_result(fixed_value_o, overflow_flag_o, bad_char_flag_o);
      end
      if (in_valid_i && in_ready_o) begin
        tracker.take_char(char_code_i, last_char_i);
      end
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IdleNone: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IdleSender: begin
        send_idle_pct  = 56;
        recv_stall_pct = 0;
      end
      IdleReceiver: begin
        send_idle_pct  = 0;
        recv_stall_pct = 56;
      end
      default: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
    endcase
  endtask

  // Starts and ends at a falling edge; valid stays high until accepted.
  task automatic send_char(char_t code, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_string(string text);
    for (int i = 0; i < text.len(); i++) begin
      send_char(char_t'(text[i]), i == text.len() - 1);
    end
  endtask

  // Drop valid, wait for every owed result, then let the pad sequencer settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_frac(frac_t digits);
    frac_digits_we_i <= 1'b1;
    frac_digits_i    <= digits;
    @(negedge clk_i);
    frac_digits_we_i <= 1'b0;
    tracker.set_frac(digits);
  endtask

  // Mostly well-formed numbers, some corrupted, some pure noise.
  task automatic send_random_number(output int unsigned chars_sent);
    char_t       text[$];
    int unsigned kind;
    int unsigned whole;
    int unsigned frac;
    int unsigned pos;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 4)) text.push_back(char_t'($urandom_range(255)));
    end else begin
      whole = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
      repeat (whole) text.push_back(dtfp_pkg::CharZero + char_t'($urandom_range(9)));
      if ($urandom_range(4) != 0) begin
        text.push_back(dtfp_pkg::CharPoint);
        frac = ($urandom_range(2) == 0) ? $urandom_range(0, 21) : $urandom_range(0, 5);
        repeat (frac) text.push_back(dtfp_pkg::CharZero + char_t'($urandom_range(9)));
      end
      if (text.size() == 0) text.push_back(dtfp_pkg::CharZero + char_t'($urandom_range(9)));
      if (kind < 25) begin
        pos = $urandom_range(0, text.size() - 1);
        text[pos] = $urandom_range(1) ? dtfp_pkg::CharPoint : char_t'($urandom_range(255));
      end
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    chars_sent = text.size();
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_chars;
    int unsigned numbers;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idle(IdleNone);

    // Directed cases at the reset setting of two fraction digits: a lone
    // point, a short fraction, a second point, negative and high character
    // values, and a fraction digit beyond the setting.
    send_string(".");
    send_string("9.5");
    send_string("1..");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_string("12.345");

    // Eighteen digits: near the top of the range, and overflow while padding.
    wait_idle();
    write_frac(5'd18);
    send_string("10");
    send_string("9");

    // No fraction digits: a trailing point, and a bad fraction character that is dropped but still flagged.
    wait_idle();
    write_frac(5'd0);
    send_string("7.");
    send_string("3.x");

    // Random phases over several settings and idle patterns.
    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      write_frac((p < 6) ? FracPlan[p] : frac_t'($urandom_range(31)));
      set_idle(idle_mode_e'(p % 4));
      phase_chars = 0;
      numbers     = 0;
      while (phase_chars < CharsPerPhase) begin
        send_random_number(sent);
        phase_chars += sent;
        numbers++;
        // Hold off the sender once per phase until the output is drained.
        if (numbers == 6) wait_idle();
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
